@@ rtl/rcfd_pkg.sv @@
`default_nettype none

package rcfd_pkg;

  // Frame layout
  localparam int FRAME_LEN = 18;
  localparam int LAST_IDX  = FRAME_LEN - 1;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = $clog2(FRAME_LEN);

  // Channel decode
  localparam int RAW_W      = 11;
  localparam int RAW_OFFSET = 1024;
  localparam int CH_W       = 11;
  localparam int CALC_W     = CH_W + 1;
  localparam int LIMIT_W    = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd660;

  // Mouse speed window
  localparam int WINDOW_LENGTH = 8;
  localparam int SLOT_W        = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int SPEED_W       = 16;
  localparam int SUM_W         = 19;
  localparam int EXT_W         = SUM_W - SPEED_W;

  // Result packing
  localparam int FIELD_W = 4 * CH_W + 2 + 2 + SPEED_W + 18 + CH_W + 2 * SUM_W;
  localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;
  localparam int PAD_W   = OUT_W - FIELD_W;

  // Byte LAST_IDX is the byte of the current transaction
  typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_t;

  typedef struct packed {
    logic   done;
    frame_t bytes;
  } frame_evt_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
  } sums_t;

  // Lowest field in the lowest bits
  typedef struct packed {
    logic        [PAD_W-1:0]   pad;
    logic signed [SUM_W-1:0]   mouse_y_window_sum;
    logic signed [SUM_W-1:0]   mouse_x_window_sum;
    logic signed [CH_W-1:0]    thumbwheel;
    logic        [17:0]        buttons_and_keys;
    logic signed [SPEED_W-1:0] mouse_z;
    logic        [1:0]         switch_right;
    logic        [1:0]         switch_left;
    logic signed [CH_W-1:0]    stick_ch3;
    logic signed [CH_W-1:0]    stick_ch2;
    logic signed [CH_W-1:0]    stick_ch1;
    logic signed [CH_W-1:0]    stick_ch0;
  } result_t;

  // Center a raw channel on zero and clamp it to +/- lim
  function automatic logic signed [CH_W-1:0] clamp_ch(input logic [RAW_W-1:0] raw,
                                                      input logic [LIMIT_W-1:0] lim);
    logic signed [CALC_W-1:0] v;
    logic signed [CALC_W-1:0] hi;
    logic signed [CALC_W-1:0] lo;
    v  = $signed({1'b0, raw}) - $signed(CALC_W'(RAW_OFFSET));
    hi = $signed(CALC_W'(lim));
    lo = -hi;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/rcfd_collect.sv @@
`default_nettype none

module rcfd_collect (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          step_i,
  input  wire [rcfd_pkg::BYTE_W-1:0]   byte_i,
  input  wire                          start_i,
  output rcfd_pkg::frame_evt_t         evt_o
);

  logic [rcfd_pkg::CNT_W-1:0] cnt_q;
  logic [rcfd_pkg::CNT_W-1:0] cnt_d;
  logic [rcfd_pkg::LAST_IDX-1:0][rcfd_pkg::BYTE_W-1:0] bytes_q;
  logic collecting;
  logic at_last;

  assign collecting = (cnt_q != '0) && (cnt_q < rcfd_pkg::CNT_W'(rcfd_pkg::LAST_IDX));
  assign at_last    = (cnt_q == rcfd_pkg::CNT_W'(rcfd_pkg::LAST_IDX));

  // Start always restarts; last byte closes the frame and goes idle
  always_comb begin
    cnt_d = cnt_q;
    if (step_i) begin
      if (start_i) begin
        cnt_d = rcfd_pkg::CNT_W'(1);
      end else if (collecting) begin
        cnt_d = cnt_q + 1'b1;
      end else if (at_last) begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Store bytes 0 through LAST_IDX-1
  always_ff @(posedge clk_i) begin
    if (step_i && start_i) begin
      bytes_q[0] <= byte_i;
    end else if (step_i && collecting) begin
      bytes_q[cnt_q] <= byte_i;
    end
  end

  assign evt_o.done  = step_i && !start_i && at_last;
  assign evt_o.bytes = {byte_i, bytes_q};

endmodule

`default_nettype wire

@@ rtl/rcfd_window.sv @@
`default_nettype none

module rcfd_window (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                done_i,
  input  wire signed [rcfd_pkg::SPEED_W-1:0] vx_i,
  input  wire signed [rcfd_pkg::SPEED_W-1:0] vy_i,
  output rcfd_pkg::sums_t                    sums_o
);

  logic signed [rcfd_pkg::SPEED_W-1:0] hist_x_q [rcfd_pkg::WINDOW_LENGTH];
  logic signed [rcfd_pkg::SPEED_W-1:0] hist_y_q [rcfd_pkg::WINDOW_LENGTH];
  logic [rcfd_pkg::SLOT_W-1:0] slot_q;
  logic [rcfd_pkg::SLOT_W-1:0] slot_d;
  logic signed [rcfd_pkg::SUM_W-1:0] x_q, y_q, x_d, y_d;
  logic signed [rcfd_pkg::SPEED_W-1:0] old_x, old_y;

  assign old_x = hist_x_q[slot_q];
  assign old_y = hist_y_q[slot_q];

  // Drop the oldest speed, add the newest
  assign x_d = x_q - {{rcfd_pkg::EXT_W{old_x[rcfd_pkg::SPEED_W-1]}}, old_x}
                   + {{rcfd_pkg::EXT_W{vx_i[rcfd_pkg::SPEED_W-1]}}, vx_i};
  assign y_d = y_q - {{rcfd_pkg::EXT_W{old_y[rcfd_pkg::SPEED_W-1]}}, old_y}
                   + {{rcfd_pkg::EXT_W{vy_i[rcfd_pkg::SPEED_W-1]}}, vy_i};

  assign slot_d = (slot_q == rcfd_pkg::SLOT_W'(rcfd_pkg::WINDOW_LENGTH - 1)) ?
                  '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      for (int i = 0; i < rcfd_pkg::WINDOW_LENGTH; i++) begin
        hist_x_q[i] <= '0;
        hist_y_q[i] <= '0;
      end
    end else if (done_i) begin
      slot_q           <= slot_d;
      x_q              <= x_d;
      y_q              <= y_d;
      hist_x_q[slot_q] <= vx_i;
      hist_y_q[slot_q] <= vy_i;
    end
  end

  assign sums_o.x = x_d;
  assign sums_o.y = y_d;

endmodule

`default_nettype wire

@@ rtl/rcfd_decode.sv @@
`default_nettype none

module rcfd_decode (
  input  rcfd_pkg::frame_t                  frame_i,
  input  wire [rcfd_pkg::LIMIT_W-1:0]       limit_i,
  input  rcfd_pkg::sums_t                   sums_i,
  output rcfd_pkg::result_t                 result_o
);

  logic [rcfd_pkg::RAW_W-1:0] raw0, raw1, raw2, raw3, raw_thumb;

  // Unpack the 11-bit channels, least significant bits first
  assign raw0      = {frame_i[1][2:0], frame_i[0]};
  assign raw1      = {frame_i[2][5:0], frame_i[1][7:3]};
  assign raw2      = {frame_i[4][0], frame_i[3], frame_i[2][7:6]};
  assign raw3      = {frame_i[5][3:0], frame_i[4][7:1]};
  assign raw_thumb = {frame_i[17][2:0], frame_i[16]};

  always_comb begin
    result_o                    = '0;
    result_o.stick_ch0          = rcfd_pkg::clamp_ch(raw0, limit_i);
    result_o.stick_ch1          = rcfd_pkg::clamp_ch(raw1, limit_i);
    result_o.stick_ch2          = rcfd_pkg::clamp_ch(raw2, limit_i);
    result_o.stick_ch3          = rcfd_pkg::clamp_ch(raw3, limit_i);
    result_o.switch_left        = frame_i[5][7:6];
    result_o.switch_right       = frame_i[5][5:4];
    result_o.mouse_z            = {frame_i[11], frame_i[10]};
    result_o.buttons_and_keys   = {frame_i[13][0], frame_i[12][0], frame_i[15], frame_i[14]};
    result_o.thumbwheel         = rcfd_pkg::clamp_ch(raw_thumb, limit_i);
    result_o.mouse_x_window_sum = sums_i.x;
    result_o.mouse_y_window_sum = sums_i.y;
  end

endmodule

`default_nettype wire

@@ rtl/rc_frame_decoder_with_mouse_average.sv @@
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: data_byte; tuser: frame_start
// m_axis    out        m_axis_tvalid/tready       tdata: one decoded frame
// cfg       in         cfg_valid/cfg_ready        cfg_data: channel_limit
//
// One byte per cycle in while m_axis is not stalled; an accepted byte passes
// through the input register and then the result register to m_axis.
// The byte counter, window history, sums and limit reset asynchronously on rst_ni.
// A stalled result holds the pipeline; the input register keeps taking a byte
// whenever it is empty or moving on, so a bubble-free stream runs at full rate.
`default_nettype none

module rc_frame_decoder_with_mouse_average (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire [rcfd_pkg::BYTE_W-1:0]         s_axis_tdata_i,  // [7:0] data_byte
  input  wire                                s_axis_tuser_i,  // [0] frame_start
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  // [10:0] stick_ch0, [21:11] stick_ch1, [32:22] stick_ch2, [43:33] stick_ch3,
  // [45:44] switch_left, [47:46] switch_right, [63:48] mouse_z,
  // [81:64] buttons_and_keys, [92:82] thumbwheel, [111:93] mouse_x_window_sum,
  // [130:112] mouse_y_window_sum, [135:131] zero
  output logic [rcfd_pkg::OUT_W-1:0]         m_axis_tdata_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [rcfd_pkg::LIMIT_W-1:0]        cfg_data_i
);

  logic                        in_valid_q, in_valid_d;
  logic [rcfd_pkg::BYTE_W-1:0] in_byte_q;
  logic                        in_start_q;
  logic                        out_valid_q, out_valid_d;
  rcfd_pkg::result_t           out_q;
  logic [rcfd_pkg::LIMIT_W-1:0] limit_q;
  logic                        advance;
  logic                        step;
  rcfd_pkg::frame_evt_t        evt;
  rcfd_pkg::sums_t             sums;
  rcfd_pkg::result_t           result;

  // Move on whenever the result register is free or being drained
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  assign in_valid_d  = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;
  assign out_valid_d = advance ? evt.done : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= rcfd_pkg::LIMIT_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  rcfd_collect u_collect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .evt_o   (evt)
  );

  rcfd_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .done_i (evt.done),
    .vx_i   ({evt.bytes[7], evt.bytes[6]}),
    .vy_i   ({evt.bytes[9], evt.bytes[8]}),
    .sums_o (sums)
  );

  rcfd_decode u_decode (
    .frame_i  (evt.bytes),
    .limit_i  (limit_q),
    .sums_i   (sums),
    .result_o (result)
  );

  // Load a finished frame into the result register
  always_ff @(posedge clk_i) begin
    if (evt.done) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/rcfd_checker.sv @@
`default_nettype none

module rcfd_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        s_axis_tvalid_i,
  input wire                        s_axis_tready_o,
  input wire                        m_axis_tvalid_o,
  input wire                        m_axis_tready_i,
  input wire [rcfd_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // No result while reset is applied
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // An empty result register never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // Clamped stick_ch0 and thumbwheel never reach the raw minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[10:0] != 11'h400) &&
                        (m_axis_tdata_o[92:82] != 11'h400))
    else $error("clamp bound exceeded");

endmodule

bind rc_frame_decoder_with_mouse_average rcfd_checker u_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int FULL_FRAME  = rcfd_pkg::FRAME_LEN;
  localparam int WIN         = rcfd_pkg::WINDOW_LENGTH;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } rc_byte_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic                             s_valid = 1'b0;
  wire                              s_tready;
  logic [rcfd_pkg::BYTE_W-1:0]      s_data  = '0;
  logic                             s_user  = 1'b0;
  wire                              m_valid;
  logic                             m_ready = 1'b0;
  wire  [rcfd_pkg::OUT_W-1:0]       m_data;
  logic                             cfg_valid = 1'b0;
  wire                              cfg_ready;
  logic [rcfd_pkg::LIMIT_W-1:0]     cfg_data  = '0;

  // Bytes waiting to be sent and frames waiting to come out
  rc_byte_t           byte_q [$];
  rcfd_pkg::result_t  decoded_q [$];

  // Decoder state mirror
  int                 limit_cfg = rcfd_pkg::LIMIT_RESET;
  int                 byte_cnt  = 0;
  logic [7:0]         frame_mem [rcfd_pkg::LAST_IDX];
  logic signed [15:0] x_hist [WIN] = '{default: '0};
  logic signed [15:0] y_hist [WIN] = '{default: '0};
  int                 slot    = 0;
  int                 x_total = 0;
  int                 y_total = 0;

  int   fail_count    = 0;
  int   cycle_count   = 0;
  logic in_taken      = 1'b0;
  int   burst_left    = 1;
  int   gap_left      = 0;
  int   tx_max_gap    = 0;
  int   rx_mode       = 0;
  int   rx_tick       = 0;
  int   hold_requests = 0;
  int   holds_served  = 0;
  int   hold_left     = 0;

  rc_frame_decoder_with_mouse_average DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_data),   // [7:0] data_byte
    .s_axis_tuser_i  (s_user),   // [0] frame_start
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // stick_ch0..3, switches, mouse_z, keys, thumbwheel, sums, pad
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Center a raw 11-bit channel and clamp it to the current limit
  function automatic logic signed [10:0] centered(input logic [10:0] raw);
    int v;
    v = int'(raw) - rcfd_pkg::RAW_OFFSET;
    if (v > limit_cfg) v = limit_cfg;
    if (v < -limit_cfg) v = -limit_cfg;
    return 11'(v);
  endfunction

  // Advance the frame collector by one byte; queue a decoded frame on byte 18
  task automatic decode_byte(input logic [7:0] data, input logic start);
    rcfd_pkg::result_t  r;
    logic [15:0]        w16;
    logic [23:0]        w24;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    if (start) begin
      frame_mem[0] = data;
      byte_cnt = 1;
    end else if (byte_cnt == 0) begin
      // idle: drop the byte
    end else if (byte_cnt < rcfd_pkg::LAST_IDX) begin
      frame_mem[byte_cnt] = data;
      byte_cnt++;
    end else begin
      byte_cnt = 0;
      r = '0;
      w16 = {frame_mem[1], frame_mem[0]};
      r.stick_ch0 = centered(w16[10:0]);
      w16 = {frame_mem[2], frame_mem[1]};
      r.stick_ch1 = centered(w16[13:3]);
      w24 = {frame_mem[4], frame_mem[3], frame_mem[2]};
      r.stick_ch2 = centered(w24[16:6]);
      w16 = {frame_mem[5], frame_mem[4]};
      r.stick_ch3 = centered(w16[11:1]);
      r.switch_left  = frame_mem[5][7:6];
      r.switch_right = frame_mem[5][5:4];
      r.mouse_z = {frame_mem[11], frame_mem[10]};
      r.buttons_and_keys = {frame_mem[13][0], frame_mem[12][0], frame_mem[15], frame_mem[14]};
      w16 = {data, frame_mem[16]};
      r.thumbwheel = centered(w16[10:0]);
      // Moving window: replace the oldest speed and keep exact sums
      vx = {frame_mem[7], frame_mem[6]};
      vy = {frame_mem[9], frame_mem[8]};
      x_total = x_total - x_hist[slot] + vx;
      y_total = y_total - y_hist[slot] + vy;
      x_hist[slot] = vx;
      y_hist[slot] = vy;
      slot = (slot + 1) % WIN;
      r.mouse_x_window_sum = x_total[rcfd_pkg::SUM_W-1:0];
      r.mouse_y_window_sum = y_total[rcfd_pkg::SUM_W-1:0];
      decoded_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic start);
    rc_byte_t b;
    b.data  = data;
    b.start = start;
    byte_q.push_back(b);
  endtask

  // Queue the first cut bytes of a frame built from its fields
  task automatic push_frame(input logic [43:0] sticks, input logic [3:0] sw,
                            input logic [10:0] thumb, input logic [15:0] vx,
                            input logic [15:0] vy, input logic [47:0] misc,
                            input logic [4:0] thumb_hi, input int cut);
    logic [47:0] head;
    logic [7:0]  fb [FULL_FRAME];
    head = {sw, sticks};
    for (int i = 0; i < 6; i++) fb[i] = head[8*i +: 8];
    fb[6] = vx[7:0];
    fb[7] = vx[15:8];
    fb[8] = vy[7:0];
    fb[9] = vy[15:8];
    for (int i = 0; i < 6; i++) fb[10+i] = misc[8*i +: 8];
    fb[16] = thumb[7:0];
    fb[17] = {thumb_hi, thumb[10:8]};
    for (int i = 0; i < cut; i++) push_byte(fb[i], i == 0);
  endtask

  task automatic push_random_frame(input int cut);
    logic [15:0] vx;
    logic [15:0] vy;
    vx = 16'($urandom);
    vy = 16'($urandom);
    // Pin the speeds to the extremes now and then to stress the sums
    if ($urandom_range(0, 7) == 0) begin
      vx = 16'h8000;
      vy = 16'h7FFF;
    end else if ($urandom_range(0, 7) == 0) begin
      vx = 16'h7FFF;
      vy = 16'h8000;
    end
    push_frame({12'($urandom), $urandom}, 4'($urandom), 11'($urandom), vx, vy,
               {16'($urandom), $urandom}, 5'($urandom), cut);
  endtask

  // Mostly whole frames; the rest are stray bytes and frames cut by a new start
  task automatic push_random_traffic(input int n_bytes);
    int added;
    int pick;
    int cut;
    added = 0;
    while (added < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) cut = FULL_FRAME;
      else if (pick < 84) cut = FULL_FRAME - 1;
      else if (pick < 92) cut = $urandom_range(1, FULL_FRAME - 2);
      else cut = 0;
      if (cut == 0) begin
        push_byte(8'($urandom), 1'b0);
        added++;
      end else begin
        push_random_frame(cut);
        added += cut;
      end
    end
  endtask

  task automatic write_limit(input logic [rcfd_pkg::LIMIT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    limit_cfg = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every byte is sent and every decoded frame has come out
  task automatic wait_idle();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || s_valid || decoded_q.size() != 0);
  endtask

  // Driver: offer bytes in bursts with random gaps
  always @(negedge clk_i) begin : tx_drive
    rc_byte_t nxt;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        nxt = byte_q.pop_front();
        s_valid <= 1'b1;
        s_data  <= nxt.data;
        s_user  <= nxt.start;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on its own pattern, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_requests > holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      rx_tick++;
      case (rx_mode)
        0: m_ready <= 1'b1;
        1: m_ready <= 1'($urandom_range(0, 1));
        2: m_ready <= ($urandom_range(0, 9) != 0);
        default: m_ready <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  // Monitor: predict on accepted bytes, check each accepted frame
  always @(posedge clk_i) begin : watch
    rcfd_pkg::result_t seen;
    rcfd_pkg::result_t want;
    in_taken <= s_valid && s_tready;
    if (rst_ni && s_valid && s_tready) begin
      decode_byte(s_data, s_user);
    end
    if (rst_ni && m_valid && m_ready) begin
      seen = m_data;
      if (decoded_q.size() == 0) begin
        $error("decoded frame transaction with no frame pending: 0x%0h", m_data);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("stick_ch0", want.stick_ch0, seen.stick_ch0);
        check_field("stick_ch1", want.stick_ch1, seen.stick_ch1);
        check_field("stick_ch2", want.stick_ch2, seen.stick_ch2);
        check_field("stick_ch3", want.stick_ch3, seen.stick_ch3);
        check_field("switch_left", want.switch_left, seen.switch_left);
        check_field("switch_right", want.switch_right, seen.switch_right);
        check_field("mouse_z", want.mouse_z, seen.mouse_z);
        check_field("buttons_and_keys", want.buttons_and_keys, seen.buttons_and_keys);
        check_field("thumbwheel", want.thumbwheel, seen.thumbwheel);
        check_field("mouse_x_window_sum", want.mouse_x_window_sum, seen.mouse_x_window_sum);
        check_field("mouse_y_window_sum", want.mouse_y_window_sum, seen.mouse_y_window_sum);
        check_field("pad", want.pad, seen.pad);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Phases: each runs at its own clamp limit and handshake pattern
  initial begin : stimulus
    int limits   [6] = '{660, 0, 1023, 0, 1, 660};
    int rx_modes [6] = '{0, 1, 2, 3, 1, 2};
    int tx_gaps  [6] = '{0, 4, 2, 6, 0, 3};
    // Assert reset with a real falling edge so the async reset takes effect
    rst_ni <= 1'b0;
    limits[3] = $urandom_range(2, 1022);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_idle();
        repeat (8) @(posedge clk_i);
        write_limit(rcfd_pkg::LIMIT_W'(limits[p]));
      end
      rx_mode    = rx_modes[p];
      tx_max_gap = tx_gaps[p];
      if (p == 2 || p == 4) hold_requests++;
      if (p == 0) begin
        // Stray byte while idle
        push_byte(8'hA5, 1'b0);
        // All-zero channels, speeds at both extremes
        push_frame('0, 4'h0, 11'h000, 16'h8000, 16'h7FFF, '0, 5'h00, FULL_FRAME);
        // All-one channels, switches and keys
        push_frame('1, 4'hF, 11'h7FF, 16'h8000, 16'h7FFF, '1, 5'h1F, FULL_FRAME);
        // Center value and both sides of the clamp bound
        push_frame({11'd1685, 11'd364, 11'd1684, 11'd1024}, 4'h9, 11'd363,
                   16'h7FFF, 16'h8000, 48'h0001_0203_0405, 5'h0A, FULL_FRAME);
        // Stray byte after a completed frame
        push_byte(8'h3C, 1'b0);
        // Start inside a frame, then on what would be the last byte
        push_random_frame(5);
        push_random_frame(FULL_FRAME);
        push_random_frame(FULL_FRAME - 1);
        push_random_frame(FULL_FRAME);
      end
      push_random_traffic((p == 0) ? 140 : 230);
    end
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
